>>> design/fel_pkg.sv
// Shared types, register codes and helper functions for the FAT entry locator.
// Used by every module of the block; has no dependencies of its own.
package fel_pkg;

    // FAT variant codes held in the fat_type register.
    localparam logic [1:0] FT_FAT12 = 2'd0;
    localparam logic [1:0] FT_FAT16 = 2'd1;
    localparam logic [1:0] FT_FAT32 = 2'd2;

    // Register indexes; register i sits at byte address 4*i.
    localparam logic [2:0] REG_FAT_TYPE        = 3'd0;
    localparam logic [2:0] REG_SECTOR_LOG2     = 3'd1;
    localparam logic [2:0] REG_RESERVED        = 3'd2;
    localparam logic [2:0] REG_FAT_COPIES      = 3'd3;
    localparam logic [2:0] REG_FAT_LENGTH      = 3'd4;
    localparam logic [2:0] REG_ROOT_ENTRIES    = 3'd5;
    localparam logic [2:0] REG_CLUSTER_SECTORS = 3'd6;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [1:0]  fat_type;
        logic [3:0]  sector_size_log2;
        logic [15:0] reserved_sectors;
        logic [7:0]  fat_copies;
        logic [31:0] fat_length_sectors;
        logic [15:0] root_entries;
        logic [7:0]  cluster_sectors;
    } t_cfg;

    // One accepted input beat.
    typedef struct packed {
        logic [27:0] cluster_number;
        logic [31:0] raw_word;
        logic [27:0] new_value;
    } t_item;

    // Values passed from the product and entry logic to the final add.
    typedef struct packed {
        logic [31:0] base_part;
        logic [31:0] prod_fat;
        logic [31:0] prod_clu;
        logic [31:0] fat_sector;
        logic [11:0] entry_byte_offset;
        logic        crosses_sector;
        logic [27:0] entry_value;
        logic [31:0] merged_word;
    } t_mid;

    // One result beat.
    typedef struct packed {
        logic [31:0] data_lba;
        logic [31:0] fat_sector;
        logic [11:0] entry_byte_offset;
        logic        crosses_sector;
        logic [27:0] entry_value;
        logic [31:0] merged_word;
    } t_result;

    // Clamp the sector size exponent to the supported 9..12 range.
    function automatic logic [3:0] eff_lg(input logic [3:0] lg);
        logic [3:0] r;
        if (lg < 4'd9) begin
            r = 4'd9;
        end else if (lg > 4'd12) begin
            r = 4'd12;
        end else begin
            r = lg;
        end
        return r;
    endfunction

    // Bytes per sector minus one for a clamped exponent.
    function automatic logic [11:0] sec_mask(input logic [3:0] lg);
        logic [12:0] m;
        m = (13'd1 << lg) - 13'd1;
        return m[11:0];
    endfunction

endpackage

>>> design/fel_regs.sv
// APB-style configuration register file for the FAT entry locator.
// Depends on fel_pkg for the register codes and the configuration struct.
module fel_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fel_pkg::ADDR_W-1:0] paddr,
    input  logic [fel_pkg::DATA_W-1:0] pwdata,
    output logic [fel_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output fel_pkg::t_cfg              o_cfg
);

    fel_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[fel_pkg::ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fat_type           <= fel_pkg::FT_FAT12;
            r_cfg.sector_size_log2   <= 4'd9;
            r_cfg.reserved_sectors   <= 16'd1;
            r_cfg.fat_copies         <= 8'd2;
            r_cfg.fat_length_sectors <= 32'd0;
            r_cfg.root_entries       <= 16'd0;
            r_cfg.cluster_sectors    <= 8'd1;
        end else if (wr_en) begin
            case (reg_idx)
                fel_pkg::REG_FAT_TYPE:        r_cfg.fat_type           <= pwdata[1:0];
                fel_pkg::REG_SECTOR_LOG2:     r_cfg.sector_size_log2   <= pwdata[3:0];
                fel_pkg::REG_RESERVED:        r_cfg.reserved_sectors   <= pwdata[15:0];
                fel_pkg::REG_FAT_COPIES:      r_cfg.fat_copies         <= pwdata[7:0];
                fel_pkg::REG_FAT_LENGTH:      r_cfg.fat_length_sectors <= pwdata;
                fel_pkg::REG_ROOT_ENTRIES:    r_cfg.root_entries       <= pwdata[15:0];
                fel_pkg::REG_CLUSTER_SECTORS: r_cfg.cluster_sectors    <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            fel_pkg::REG_FAT_TYPE:        prdata = 32'(r_cfg.fat_type);
            fel_pkg::REG_SECTOR_LOG2:     prdata = 32'(r_cfg.sector_size_log2);
            fel_pkg::REG_RESERVED:        prdata = 32'(r_cfg.reserved_sectors);
            fel_pkg::REG_FAT_COPIES:      prdata = 32'(r_cfg.fat_copies);
            fel_pkg::REG_FAT_LENGTH:      prdata = r_cfg.fat_length_sectors;
            fel_pkg::REG_ROOT_ENTRIES:    prdata = 32'(r_cfg.root_entries);
            fel_pkg::REG_CLUSTER_SECTORS: prdata = 32'(r_cfg.cluster_sectors);
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

>>> design/fel_front.sv
// Front half of the datapath: the two products, the FAT entry position and the entry pack.
// Depends on fel_pkg for the item, configuration and intermediate structs.
module fel_front (
    input  fel_pkg::t_cfg  i_cfg,
    input  fel_pkg::t_item i_item,
    output fel_pkg::t_mid  o_mid
);

    always_comb begin
        logic [3:0]  lg;
        logic [11:0] mask;
        logic        short_fat;
        logic [21:0] root_bytes;
        logic [21:0] root_secs;
        logic [31:0] cl_m2;
        logic [29:0] boff;
        logic [15:0] w;
        logic [27:0] cl;
        logic [27:0] nv;

        cl   = i_item.cluster_number;
        nv   = i_item.new_value;
        w    = i_item.raw_word[15:0];
        lg   = fel_pkg::eff_lg(i_cfg.sector_size_log2);
        mask = fel_pkg::sec_mask(lg);

        short_fat  = (i_cfg.fat_type == fel_pkg::FT_FAT12) ||
                     (i_cfg.fat_type == fel_pkg::FT_FAT16);
        root_bytes = {1'b0, i_cfg.root_entries, 5'd0} + {10'd0, mask};
        root_secs  = root_bytes >> lg;

        o_mid.base_part = 32'(i_cfg.reserved_sectors) +
                          (short_fat ? 32'(root_secs) : 32'd0);
        o_mid.prod_fat  = 32'(40'(i_cfg.fat_copies) * 40'(i_cfg.fat_length_sectors));

        // Clusters below two wrap before the multiply, as on a 32-bit machine.
        cl_m2          = 32'(cl) - 32'd2;
        o_mid.prod_clu = 32'(40'(cl_m2) * 40'(i_cfg.cluster_sectors));

        case (i_cfg.fat_type)
            fel_pkg::FT_FAT12: begin
                boff = 30'(cl) + 30'(cl >> 1);
                if (cl[0]) begin
                    o_mid.entry_value = 28'(w[15:4]);
                    o_mid.merged_word = 32'({nv[11:0], w[3:0]});
                end else begin
                    o_mid.entry_value = 28'(w[11:0]);
                    o_mid.merged_word = 32'({w[15:12], nv[11:0]});
                end
            end
            fel_pkg::FT_FAT16: begin
                boff              = {1'b0, cl, 1'b0};
                o_mid.entry_value = 28'(w);
                o_mid.merged_word = 32'(nv[15:0]);
            end
            default: begin
                // FAT32 and the unused code: top nibble of the raw word is reserved.
                boff              = {cl, 2'b00};
                o_mid.entry_value = i_item.raw_word[27:0];
                o_mid.merged_word = {i_item.raw_word[31:28], nv};
            end
        endcase

        o_mid.fat_sector        = 32'(i_cfg.reserved_sectors) + 32'(boff >> lg);
        o_mid.entry_byte_offset = boff[11:0] & mask;
        o_mid.crosses_sector    = (i_cfg.fat_type == fel_pkg::FT_FAT12) &&
                                  ((boff[11:0] & mask) == mask);
    end

endmodule

>>> design/fel_back.sv
// Back half of the datapath: the data LBA sum and assembly of the result beat.
// Depends on fel_pkg for the intermediate and result structs.
module fel_back (
    input  fel_pkg::t_mid    i_mid,
    output fel_pkg::t_result o_res
);

    always_comb begin
        o_res.data_lba          = i_mid.base_part + i_mid.prod_fat + i_mid.prod_clu;
        o_res.fat_sector        = i_mid.fat_sector;
        o_res.entry_byte_offset = i_mid.entry_byte_offset;
        o_res.crosses_sector    = i_mid.crosses_sector;
        o_res.entry_value       = i_mid.entry_value;
        o_res.merged_word       = i_mid.merged_word;
    end

endmodule

>>> design/fat_entry_locate_and_pack.sv
// FAT12/FAT16/FAT32 cluster locator and FAT entry packer. Each input beat carries a
// cluster number, the raw little-endian bytes read at its FAT entry and a new entry
// value; each produces exactly one result beat with the cluster's first data sector,
// the sector and byte offset of its FAT entry, a FAT12 sector-straddle flag, the
// extracted entry and the write-back word with the new value merged in. The block
// accepts one beat per clock cycle unless o_in_stall holds it back. An accepted beat
// is loaded into the input register, and a single combinational pass (a 32x8 multiply
// for the FAT area and one for the cluster offset, the entry position and pack, then
// the three-input add that forms the data LBA) computes its result, which is loaded
// into the result register when that register is free or its beat is taken. Beats stay
// in order, and a stalled output only holds the input back once both registers are
// full. Configuration is written through the APB-style port and must only change
// while no beat is in flight.
module fat_entry_locate_and_pack (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fel_pkg::ADDR_W-1:0] paddr,
    input  logic [fel_pkg::DATA_W-1:0] pwdata,
    output logic [fel_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    // Input channel.
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [27:0]                i_cluster_number,
    input  logic [31:0]                i_raw_word,
    input  logic [27:0]                i_new_value,
    // Result channel.
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [31:0]                o_data_lba,
    output logic [31:0]                o_fat_sector,
    output logic [11:0]                o_entry_byte_offset,
    output logic                       o_crosses_sector,
    output logic [27:0]                o_entry_value,
    output logic [31:0]                o_merged_word
);

    fel_pkg::t_cfg    w_cfg;
    fel_pkg::t_item   r_s1;
    fel_pkg::t_mid    w_mid;
    fel_pkg::t_result r_out;
    fel_pkg::t_result n_out;
    logic             r_s1_valid;
    logic             r_out_valid;
    logic             out_en;
    logic             s1_en;

    fel_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fel_front u_front (
        .i_cfg  (w_cfg),
        .i_item (r_s1),
        .o_mid  (w_mid)
    );

    fel_back u_back (
        .i_mid (w_mid),
        .o_res (n_out)
    );

    // Each register loads when it is empty or when the register after it moves,
    // so bubbles are squeezed out and a stall only reaches the input when both are full.
    assign out_en     = !r_out_valid || !i_out_stall;
    assign s1_en      = !r_s1_valid || out_en;
    assign o_in_stall = !s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_en) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_en) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1.cluster_number <= i_cluster_number;
            r_s1.raw_word       <= i_raw_word;
            r_s1.new_value      <= i_new_value;
        end
        if (out_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_data_lba          = r_out.data_lba;
    assign o_fat_sector        = r_out.fat_sector;
    assign o_entry_byte_offset = r_out.entry_byte_offset;
    assign o_crosses_sector    = r_out.crosses_sector;
    assign o_entry_value       = r_out.entry_value;
    assign o_merged_word       = r_out.merged_word;

`ifndef NO_ASSERTIONS
    // A beat in the input register that cannot move on must not be lost.
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_en |=> r_s1_valid)
        else $error("input register beat dropped while blocked");

    // The input only stalls when both registers hold a beat.
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid)
        else $error("input stalled with a free pipeline slot");

    // Only FAT12 entries can straddle a sector boundary.
    a_cross_fat12 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_crosses_sector |-> w_cfg.fat_type == fel_pkg::FT_FAT12)
        else $error("sector straddle flagged outside FAT12");

    // The entry offset always lies inside one sector.
    a_off_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_byte_offset &
            ~fel_pkg::sec_mask(fel_pkg::eff_lg(w_cfg.sector_size_log2))) == 12'd0)
        else $error("entry offset beyond the sector size");

    // FAT12 and FAT16 write-back words are sixteen bits wide.
    a_merge_width : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (w_cfg.fat_type == fel_pkg::FT_FAT12 ||
            w_cfg.fat_type == fel_pkg::FT_FAT16) |-> o_merged_word[31:16] == 16'd0)
        else $error("upper half of a short write-back word is set");
`endif

endmodule

>>> tb/fel_result_checker.sv
// Result checker for the FAT entry locator: it follows the configuration port, computes the
// expected location and entry words for every accepted input beat and compares result beats.
// Depends on fel_pkg for the configuration, item and result types and the register codes.
module fel_result_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [fel_pkg::ADDR_W-1:0] paddr,
    input  logic [fel_pkg::DATA_W-1:0] pwdata,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [27:0]                i_cluster_number,
    input  logic [31:0]                i_raw_word,
    input  logic [27:0]                i_new_value,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [31:0]                i_data_lba,
    input  logic [31:0]                i_fat_sector,
    input  logic [11:0]                i_entry_byte_offset,
    input  logic                       i_crosses_sector,
    input  logic [27:0]                i_entry_value,
    input  logic [31:0]                i_merged_word,
    output int                         o_pending,
    output int                         o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    fel_pkg::t_cfg    volume;
    fel_pkg::t_item   lookup;
    fel_pkg::t_result want;
    fel_pkg::t_result expected_locations[$];
    int               bad;

    // Computes the data LBA, FAT entry position, extracted entry and write-back word.
    function automatic fel_pkg::t_result locate_cluster(input fel_pkg::t_cfg v,
                                                        input fel_pkg::t_item it);
        logic [3:0]       lg;
        logic [31:0]      bps_mask;
        logic [31:0]      root_secs;
        logic [31:0]      first_data;
        logic [31:0]      byte_pos;
        logic [31:0]      cl32;
        logic [15:0]      w;
        logic             small_fat;
        fel_pkg::t_result r;
        lg = v.sector_size_log2;
        if (lg < 4'd9) begin
            lg = 4'd9;
        end else if (lg > 4'd12) begin
            lg = 4'd12;
        end
        bps_mask  = (32'd1 << lg) - 32'd1;
        small_fat = (v.fat_type == fel_pkg::FT_FAT12) || (v.fat_type == fel_pkg::FT_FAT16);
        root_secs = (({16'd0, v.root_entries} << 5) + bps_mask) >> lg;
        first_data = {16'd0, v.reserved_sectors} + {24'd0, v.fat_copies} * v.fat_length_sectors
                   + (small_fat ? root_secs : 32'd0);
        cl32 = {4'd0, it.cluster_number};
        r.data_lba = first_data + (cl32 - 32'd2) * {24'd0, v.cluster_sectors};
        w = it.raw_word[15:0];
        case (v.fat_type)
            fel_pkg::FT_FAT12: begin
                byte_pos = cl32 + (cl32 >> 1);
                if (cl32[0]) begin
                    r.entry_value = {16'd0, w[15:4]};
                    r.merged_word = {16'd0, it.new_value[11:0], w[3:0]};
                end else begin
                    r.entry_value = {16'd0, w[11:0]};
                    r.merged_word = {16'd0, w[15:12], it.new_value[11:0]};
                end
            end
            fel_pkg::FT_FAT16: begin
                byte_pos      = cl32 << 1;
                r.entry_value = {12'd0, w};
                r.merged_word = {16'd0, it.new_value[15:0]};
            end
            default: begin
                // The unused variant code takes the FAT32 path as well.
                byte_pos      = cl32 << 2;
                r.entry_value = it.raw_word[27:0];
                r.merged_word = {it.raw_word[31:28], it.new_value};
            end
        endcase
        r.fat_sector        = {16'd0, v.reserved_sectors} + (byte_pos >> lg);
        r.entry_byte_offset = byte_pos[11:0] & bps_mask[11:0];
        r.crosses_sector    = (v.fat_type == fel_pkg::FT_FAT12) &&
                              (r.entry_byte_offset == bps_mask[11:0]);
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [31:0] exp_val,
                                         input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            volume.fat_type           <= fel_pkg::FT_FAT12;
            volume.sector_size_log2   <= 4'd9;
            volume.reserved_sectors   <= 16'd1;
            volume.fat_copies         <= 8'd2;
            volume.fat_length_sectors <= 32'd0;
            volume.root_entries       <= 16'd0;
            volume.cluster_sectors    <= 8'd1;
            expected_locations.delete();
            o_pending    <= 0;
            o_mismatches <= 0;
        end else begin
            bad = 0;
            if (psel && penable && pwrite && pready) begin
                case (paddr[fel_pkg::ADDR_W-1:2])
                    fel_pkg::REG_FAT_TYPE:        volume.fat_type           <= pwdata[1:0];
                    fel_pkg::REG_SECTOR_LOG2:     volume.sector_size_log2   <= pwdata[3:0];
                    fel_pkg::REG_RESERVED:        volume.reserved_sectors   <= pwdata[15:0];
                    fel_pkg::REG_FAT_COPIES:      volume.fat_copies         <= pwdata[7:0];
                    fel_pkg::REG_FAT_LENGTH:      volume.fat_length_sectors <= pwdata[31:0];
                    fel_pkg::REG_ROOT_ENTRIES:    volume.root_entries       <= pwdata[15:0];
                    fel_pkg::REG_CLUSTER_SECTORS: volume.cluster_sectors    <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_locations.size() == 0) begin
                    $error("result beat arrived with no cluster lookup outstanding");
                    bad++;
                end else begin
                    want = expected_locations.pop_front();
                    bad += field_differs("data_lba", want.data_lba, i_data_lba);
                    bad += field_differs("fat_sector", want.fat_sector, i_fat_sector);
                    bad += field_differs("entry_byte_offset", 32'(want.entry_byte_offset),
                                         32'(i_entry_byte_offset));
                    bad += field_differs("crosses_sector", 32'(want.crosses_sector),
                                         32'(i_crosses_sector));
                    bad += field_differs("entry_value", 32'(want.entry_value),
                                         32'(i_entry_value));
                    bad += field_differs("merged_word", want.merged_word, i_merged_word);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                lookup.cluster_number = i_cluster_number;
                lookup.raw_word       = i_raw_word;
                lookup.new_value      = i_new_value;
                expected_locations.push_back(locate_cluster(volume, lookup));
            end
            o_pending    <= expected_locations.size();
            o_mismatches <= o_mismatches + bad;
        end
    end

endmodule

>>> tb/fat_entry_locate_and_pack_test.sv
// Top of the FAT entry locator testbench: clock, reset, register programming, input beats,
// output back-pressure, a watchdog and the verdict. Depends on fel_pkg, the block itself
// and fel_result_checker, which does all prediction and comparison.
module fat_entry_locate_and_pack_test;
    timeunit 1ns;
    timeprecision 1ps;

    // The fat_type code that names no variant, and a register index with no register behind it.
    localparam logic [1:0] FT_UNUSED  = 2'd3;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // Cycles without any accepted beat or register access before the run is declared hung.
    localparam int HANG_LIMIT = 5000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [fel_pkg::ADDR_W-1:0] paddr;
    logic [fel_pkg::DATA_W-1:0] pwdata;
    logic [fel_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [27:0]                i_cluster_number;
    logic [31:0]                i_raw_word;
    logic [27:0]                i_new_value;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [31:0]                o_data_lba;
    logic [31:0]                o_fat_sector;
    logic [11:0]                o_entry_byte_offset;
    logic                       o_crosses_sector;
    logic [27:0]                o_entry_value;
    logic [31:0]                o_merged_word;

    int                         pending_lookups;
    int                         mismatches;
    logic                       idle_on = 1'b0;
    int                         stall_burst = 0;
    int                         hang_cycles = 0;
    // Clamped sector size exponent last programmed; only used to aim clusters at sector ends.
    int                         stim_lg = 9;

    fat_entry_locate_and_pack DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_cluster_number    (i_cluster_number),
        .i_raw_word          (i_raw_word),
        .i_new_value         (i_new_value),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_data_lba          (o_data_lba),
        .o_fat_sector        (o_fat_sector),
        .o_entry_byte_offset (o_entry_byte_offset),
        .o_crosses_sector    (o_crosses_sector),
        .o_entry_value       (o_entry_value),
        .o_merged_word       (o_merged_word)
    );

    fel_result_checker result_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .pready              (pready),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_cluster_number    (i_cluster_number),
        .i_raw_word          (i_raw_word),
        .i_new_value         (i_new_value),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_data_lba          (o_data_lba),
        .i_fat_sector        (o_fat_sector),
        .i_entry_byte_offset (o_entry_byte_offset),
        .i_crosses_sector    (o_crosses_sector),
        .i_entry_value       (o_entry_value),
        .i_merged_word       (o_merged_word),
        .o_pending           (pending_lookups),
        .o_mismatches        (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver back-pressure. Roughly one cycle in nine is stalled, and now and then a stall
    // stretches over several cycles so that all pipeline stages fill up behind it. With idling
    // off the result channel never stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            i_out_stall <= 1'b0;
            stall_burst <= 0;
        end else if (stall_burst > 0) begin
            i_out_stall <= 1'b1;
            stall_burst <= stall_burst - 1;
        end else if ($urandom_range(0, 99) < 11) begin
            i_out_stall <= 1'b1;
            if ($urandom_range(0, 19) == 0) begin
                stall_burst <= $urandom_range(3, 15);
            end
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog: any accepted beat or register access restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable)) begin
            hang_cycles <= 0;
        end else if (hang_cycles >= HANG_LIMIT) begin
            $display("fat_entry_locate_and_pack_test: errors");
            $finish;
        end else begin
            hang_cycles <= hang_cycles + 1;
        end
    end

    // One register write: a setup cycle, then an access cycle that completes on pready.
    // It always starts on a fresh clock edge so psel drops between writes.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == fel_pkg::REG_SECTOR_LOG2) begin
            stim_lg = (value[3:0] < 4'd9) ? 9 : (value[3:0] > 4'd12) ? 12 : int'(value[3:0]);
        end
    endtask

    // Presents one input beat and returns at the edge where it is accepted. Valid stays high
    // afterwards, so back-to-back beats drop valid in between only when a random gap is inserted.
    task automatic send_lookup(input logic [27:0] cl, input logic [31:0] raw,
                               input logic [27:0] nv);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < 11) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 12) : 1;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_cluster_number <= cl;
        i_raw_word       <= raw;
        i_new_value      <= nv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Holds the sender back until every accepted beat has come back as a result. The checker
    // updates its count at the clock edge, so the count is read only after that edge.
    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_lookups != 0) @(posedge i_clk);
    endtask

    // A FAT12 cluster whose entry starts on the last byte of a sector. Entry byte offsets are
    // never 2 modulo 3, so the target is moved one sector on until it can be reached.
    function automatic logic [27:0] straddling_cluster(input int lg);
        logic [31:0] target;
        target = ($urandom_range(0, 60000) << lg) + ((32'd1 << lg) - 32'd1);
        while (target % 3 == 2) target = target + (32'd1 << lg);
        if (target % 3 == 0) begin
            return 28'(target * 2 / 3);
        end
        return 28'((target - 1) / 3 * 2 + 1);
    endfunction

    // Register value: often an extreme, sometimes a typical value, otherwise anything at all,
    // including junk above the register's width.
    function automatic logic [31:0] pick_value(input int lo, input int hi);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            return 32'd0;
        end else if (sel < 4) begin
            return 32'hFFFF_FFFF;
        end else if (sel < 7) begin
            return $urandom_range(lo, hi);
        end
        return $urandom;
    endfunction

    initial begin
        int          phase;
        int          sel;
        logic [27:0] cl;
        logic [31:0] raw;

        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        i_in_valid       <= 1'b0;
        i_cluster_number <= '0;
        i_raw_word       <= '0;
        i_new_value      <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, starting from the reset configuration (FAT12, 512-byte sectors).
        // Clusters 0 and 1 make the cluster offset wrap; 341 is an odd entry that straddles
        // the sector end and 340 its even neighbor; the top cluster checks the full width.
        send_lookup(28'd0, 32'h0000_0000, 28'h000_0000);
        send_lookup(28'd1, 32'hFFFF_FFFF, 28'hFFF_FFFF);
        send_lookup(28'd2, 32'hA5C3_5A3C, 28'h000_0ABC);
        send_lookup(28'd3, 32'h1234_5678, 28'h000_0FFF);
        send_lookup(28'd341, 32'h0000_BEEF, 28'h012_3456);
        send_lookup(28'd340, 32'hFFFF_0000, 28'h000_0000);
        send_lookup(28'hFFF_FFFF, 32'hFFFF_FFFF, 28'hFFF_FFFF);
        drain();

        // FAT16 with reserved sectors, FAT copies, FAT length and root entries at their maximum, so the data LBA wraps.
        write_reg(fel_pkg::REG_FAT_TYPE, {30'd0, fel_pkg::FT_FAT16});
        write_reg(fel_pkg::REG_SECTOR_LOG2, 32'd10);
        write_reg(fel_pkg::REG_RESERVED, 32'h0000_FFFF);
        write_reg(fel_pkg::REG_FAT_COPIES, 32'd255);
        write_reg(fel_pkg::REG_FAT_LENGTH, 32'hFFFF_FFFF);
        write_reg(fel_pkg::REG_ROOT_ENTRIES, 32'h0000_FFFF);
        write_reg(fel_pkg::REG_CLUSTER_SECTORS, 32'd128);
        send_lookup(28'd0, 32'h8000_0001, 28'hFFF_FFFF);
        send_lookup(28'hFFF_FFFF, $urandom, 28'($urandom));
        send_lookup(28'd2, 32'h0000_FFFF, 28'h000_0000);
        drain();

        // FAT32 with zero copies and zero sectors per cluster; an exponent below 9 acts as 9.
        write_reg(fel_pkg::REG_FAT_TYPE, {30'd0, fel_pkg::FT_FAT32});
        write_reg(fel_pkg::REG_SECTOR_LOG2, 32'd0);
        write_reg(fel_pkg::REG_RESERVED, 32'd0);
        write_reg(fel_pkg::REG_FAT_COPIES, 32'd0);
        write_reg(fel_pkg::REG_FAT_LENGTH, 32'd0);
        write_reg(fel_pkg::REG_ROOT_ENTRIES, 32'd0);
        write_reg(fel_pkg::REG_CLUSTER_SECTORS, 32'd0);
        send_lookup(28'd1, 32'hF000_0000, 28'hFFF_FFFF);
        send_lookup(28'hFFF_FFFF, 32'h0FFF_FFFF, 28'h000_0000);
        send_lookup(28'd5, 32'h5A5A_5A5A, 28'hA5A_5A5A);
        drain();

        // The unused variant code behaves as FAT32, an exponent above 12 acts as 12, and a
        // write to an index with no register must change nothing.
        write_reg(fel_pkg::REG_FAT_TYPE, {30'd0, FT_UNUSED});
        write_reg(fel_pkg::REG_SECTOR_LOG2, 32'd15);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        write_reg(fel_pkg::REG_CLUSTER_SECTORS, 32'd1);
        send_lookup(28'd1000, $urandom, 28'($urandom));
        send_lookup(28'd0, 32'hFFFF_FFFF, 28'h000_0000);
        drain();

        // FAT12 straddles: an even entry on 4096-byte sectors, even and odd entries on 1024-byte sectors.
        write_reg(fel_pkg::REG_FAT_TYPE, {30'd0, fel_pkg::FT_FAT12});
        write_reg(fel_pkg::REG_SECTOR_LOG2, 32'd12);
        send_lookup(28'd2730, 32'h0000_ABCD, 28'h000_0321);
        send_lookup(28'd1365, 32'h0000_DCBA, 28'h000_0FFF);
        drain();
        write_reg(fel_pkg::REG_SECTOR_LOG2, 32'd10);
        send_lookup(28'd682, 32'hFFFF_FFFF, 28'h000_0000);
        send_lookup(28'd1365, 32'h0000_0000, 28'hFFF_FFFF);
        drain();

        // Random part: each phase programs a fresh volume, then streams lookups. The variant
        // cycles through all four codes; phase 4 runs with no idling on either channel.
        for (phase = 0; phase < 12; phase++) begin
            idle_on <= (phase != 4);
            write_reg(fel_pkg::REG_FAT_TYPE,
                      {30'($urandom_range(0, 32'h3FFF_FFFF)), phase[1:0]});
            write_reg(fel_pkg::REG_SECTOR_LOG2,
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(9, 12));
            write_reg(fel_pkg::REG_RESERVED, pick_value(1, 64));
            write_reg(fel_pkg::REG_FAT_COPIES, pick_value(1, 2));
            write_reg(fel_pkg::REG_FAT_LENGTH, pick_value(1, 8192));
            write_reg(fel_pkg::REG_ROOT_ENTRIES, pick_value(0, 512));
            write_reg(fel_pkg::REG_CLUSTER_SECTORS, pick_value(1, 128));
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_UNUSED, $urandom);
            end
            repeat (155) begin
                // Clusters: anywhere, very low (offset wrap), on a sector end, at the top
                // of the range, or within a typical small volume.
                sel = $urandom_range(0, 19);
                if (sel < 8) begin
                    cl = 28'($urandom_range(0, 28'hFFF_FFFF));
                end else if (sel < 12) begin
                    cl = 28'($urandom_range(0, 15));
                end else if (sel < 15) begin
                    cl = straddling_cluster(stim_lg);
                end else if (sel < 17) begin
                    cl = 28'(28'hFFF_FFFF - $urandom_range(0, 15));
                end else begin
                    cl = 28'($urandom_range(0, 65535));
                end
                raw = $urandom;
                if ($urandom_range(0, 9) == 0) begin
                    raw = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                end
                send_lookup(cl, raw, 28'($urandom));
            end
            drain();
        end

        // Wait so that any stray result beat can show before the verdict.
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("fat_entry_locate_and_pack_test: clean");
        end else begin
            $display("fat_entry_locate_and_pack_test: errors");
        end
        $finish;
    end

endmodule
